// File: rtl/core/sorb_pkg.sv
// Shared types, constants and helpers for the signed OR range bounds core.
// No dependencies.
package sorb_pkg;

   localparam int FIELD_W   = 32;
   localparam int MAX_WIDTH = 64;
   localparam int DEF_WIDTH = 32;

   // sign patterns of {a_low, a_high, b_low, b_high}, 1 = negative
   localparam logic [3:0] SGN_D_POS   = 4'b1110;
   localparam logic [3:0] SGN_B_POS   = 4'b1011;
   localparam logic [3:0] SGN_B_D_POS = 4'b1010;
   localparam logic [3:0] SGN_A_NEG   = 4'b1000;
   localparam logic [3:0] SGN_C_NEG   = 4'b0010;

   typedef struct packed {
      logic bad;
      logic min_fix;
      logic max_fix;
   } ctl_type;

   // one-hot of the highest set bit, zero for zero
   function automatic logic [MAX_WIDTH-1:0] highest_one(input logic [MAX_WIDTH-1:0] v);
      logic [MAX_WIDTH-1:0] s;
      s = v;
      for (int k = 1; k < MAX_WIDTH; k = k * 2) begin
         s = s | (s >> k);
      end
      return s ^ (s >> 1);
   endfunction

endpackage

// File: rtl/core/sorb_prep.sv
// First stage: width conversion, reversed range check, sign case decode.
// Uses sorb_pkg.
module sorb_prep #(
   parameter int WIDTH = sorb_pkg::DEF_WIDTH
) (
   input  logic                              clock,
   input  logic                              load,
   input  logic signed [sorb_pkg::FIELD_W-1:0] a_low,
   input  logic signed [sorb_pkg::FIELD_W-1:0] a_high,
   input  logic signed [sorb_pkg::FIELD_W-1:0] b_low,
   input  logic signed [sorb_pkg::FIELD_W-1:0] b_high,
   output sorb_pkg::ctl_type                  ctl,
   output logic [WIDTH-1:0]                   min_a,
   output logic [WIDTH-1:0]                   min_b,
   output logic [WIDTH-1:0]                   min_c,
   output logic [WIDTH-1:0]                   min_d,
   output logic [WIDTH-1:0]                   max_a,
   output logic [WIDTH-1:0]                   max_b,
   output logic [WIDTH-1:0]                   max_c,
   output logic [WIDTH-1:0]                   max_d,
   output logic [WIDTH-1:0]                   min_val
);
   import sorb_pkg::*;

   logic [WIDTH-1:0] a, b, c, d;
   logic [3:0]       sgn;
   ctl_type          ctl_in, ctl_ff;
   logic [WIDTH-1:0] min_a_in, min_b_in, min_c_in, min_d_in;
   logic [WIDTH-1:0] max_a_in, max_b_in, max_c_in, max_d_in;
   logic [WIDTH-1:0] min_val_in;
   logic [WIDTH-1:0] min_a_ff, min_b_ff, min_c_ff, min_d_ff;
   logic [WIDTH-1:0] max_a_ff, max_b_ff, max_c_ff, max_d_ff;
   logic [WIDTH-1:0] min_val_ff;

   assign a   = WIDTH'(a_low);
   assign b   = WIDTH'(a_high);
   assign c   = WIDTH'(b_low);
   assign d   = WIDTH'(b_high);
   assign sgn = {a[WIDTH-1], b[WIDTH-1], c[WIDTH-1], d[WIDTH-1]};

   always_comb begin
      ctl_in.bad     = ($signed(b) < $signed(a)) || ($signed(d) < $signed(c));
      ctl_in.min_fix = 1'b0;
      ctl_in.max_fix = 1'b0;
      min_val_in     = a;
      min_a_in       = a;
      min_b_in       = b;
      min_c_in       = c;
      min_d_in       = d;
      max_a_in       = a;
      max_b_in       = b;
      max_c_in       = c;
      max_d_in       = d;
      case (sgn)
         SGN_D_POS: begin
            ctl_in.min_fix = 1'b1;
            ctl_in.max_fix = 1'b1;
            min_val_in     = a;
         end
         SGN_B_POS: begin
            ctl_in.min_fix = 1'b1;
            ctl_in.max_fix = 1'b1;
            min_val_in     = c;
         end
         SGN_B_D_POS: begin
            ctl_in.min_fix = 1'b1;
            min_val_in     = ($signed(a) < $signed(c)) ? a : c;
            max_a_in       = '0;
            max_c_in       = '0;
         end
         SGN_A_NEG: begin
            min_b_in = '1;
            max_a_in = '0;
         end
         SGN_C_NEG: begin
            min_d_in = '1;
            max_c_in = '0;
         end
         default: begin
            ctl_in.min_fix = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctl_ff     <= ctl_in;
         min_val_ff <= min_val_in;
         min_a_ff   <= min_a_in;
         min_b_ff   <= min_b_in;
         min_c_ff   <= min_c_in;
         min_d_ff   <= min_d_in;
         max_a_ff   <= max_a_in;
         max_b_ff   <= max_b_in;
         max_c_ff   <= max_c_in;
         max_d_ff   <= max_d_in;
      end
   end

   assign ctl     = ctl_ff;
   assign min_val = min_val_ff;
   assign min_a   = min_a_ff;
   assign min_b   = min_b_ff;
   assign min_c   = min_c_ff;
   assign min_d   = min_d_ff;
   assign max_a   = max_a_ff;
   assign max_b   = max_b_ff;
   assign max_c   = max_c_ff;
   assign max_d   = max_d_ff;

endmodule

// File: rtl/core/sorb_scan.sv
// Second stage: per-bit candidate tests of the bit scan, all positions at once.
// Uses sorb_pkg.
module sorb_scan #(
   parameter int WIDTH = sorb_pkg::DEF_WIDTH
) (
   input  logic               clock,
   input  logic               load,
   input  sorb_pkg::ctl_type  ctl_i,
   input  logic [WIDTH-1:0]   min_a,
   input  logic [WIDTH-1:0]   min_b,
   input  logic [WIDTH-1:0]   min_c,
   input  logic [WIDTH-1:0]   min_d,
   input  logic [WIDTH-1:0]   max_a,
   input  logic [WIDTH-1:0]   max_b,
   input  logic [WIDTH-1:0]   max_c,
   input  logic [WIDTH-1:0]   max_d,
   input  logic [WIDTH-1:0]   min_val_i,
   output sorb_pkg::ctl_type  ctl_o,
   output logic [WIDTH-1:0]   lo_a,
   output logic [WIDTH-1:0]   lo_c,
   output logic [WIDTH-1:0]   hi_b,
   output logic [WIDTH-1:0]   hi_d,
   output logic [WIDTH-1:0]   min_val_o,
   output logic [WIDTH-1:0]   hit_a,
   output logic [WIDTH-1:0]   hit_c,
   output logic [WIDTH-1:0]   hit_b,
   output logic [WIDTH-1:0]   hit_d
);
   import sorb_pkg::*;

   logic [WIDTH-1:0] hit_a_in, hit_c_in, hit_b_in, hit_d_in;
   logic [WIDTH-1:0] hit_a_ff, hit_c_ff, hit_b_ff, hit_d_ff;
   logic [WIDTH-1:0] lo_a_ff, lo_c_ff, hi_b_ff, hi_d_ff, min_val_ff;
   ctl_type          ctl_ff;

   for (genvar i = 0; i < WIDTH; i++) begin : g_bit
      localparam logic [WIDTH-1:0] M   = WIDTH'(1) << i;
      localparam logic [WIDTH-1:0] LOW = M - WIDTH'(1);
      logic [WIDTH-1:0] ta, tc, tb, td;
      logic             keep_b;
      assign ta          = (min_a | M) & ~LOW;
      assign tc          = (min_c | M) & ~LOW;
      assign tb          = (max_b & ~M) | LOW;
      assign td          = (max_d & ~M) | LOW;
      assign keep_b      = tb >= max_a;
      assign hit_a_in[i] = ~min_a[i] & min_c[i] & (ta <= min_b);
      assign hit_c_in[i] = min_a[i] & ~min_c[i] & (tc <= min_d);
      assign hit_b_in[i] = max_b[i] & max_d[i] & keep_b;
      assign hit_d_in[i] = max_b[i] & max_d[i] & ~keep_b & (td >= max_c);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctl_ff     <= ctl_i;
         lo_a_ff    <= min_a;
         lo_c_ff    <= min_c;
         hi_b_ff    <= max_b;
         hi_d_ff    <= max_d;
         min_val_ff <= min_val_i;
         hit_a_ff   <= hit_a_in;
         hit_c_ff   <= hit_c_in;
         hit_b_ff   <= hit_b_in;
         hit_d_ff   <= hit_d_in;
      end
   end

   assign ctl_o     = ctl_ff;
   assign lo_a      = lo_a_ff;
   assign lo_c      = lo_c_ff;
   assign hi_b      = hi_b_ff;
   assign hi_d      = hi_d_ff;
   assign min_val_o = min_val_ff;
   assign hit_a     = hit_a_ff;
   assign hit_c     = hit_c_ff;
   assign hit_b     = hit_b_ff;
   assign hit_d     = hit_d_ff;

endmodule

// File: rtl/core/sorb_pick.sv
// Third stage: picks the highest candidate bit, forms the bounds, output register.
// Uses sorb_pkg.
module sorb_pick #(
   parameter int WIDTH = sorb_pkg::DEF_WIDTH
) (
   input  logic                                clock,
   input  logic                                load,
   input  sorb_pkg::ctl_type                   ctl,
   input  logic [WIDTH-1:0]                    lo_a,
   input  logic [WIDTH-1:0]                    lo_c,
   input  logic [WIDTH-1:0]                    hi_b,
   input  logic [WIDTH-1:0]                    hi_d,
   input  logic [WIDTH-1:0]                    min_val,
   input  logic [WIDTH-1:0]                    hit_a,
   input  logic [WIDTH-1:0]                    hit_c,
   input  logic [WIDTH-1:0]                    hit_b,
   input  logic [WIDTH-1:0]                    hit_d,
   output logic signed [sorb_pkg::FIELD_W-1:0] or_min,
   output logic signed [sorb_pkg::FIELD_W-1:0] or_max,
   output logic                                bad_range
);
   import sorb_pkg::*;

   logic [WIDTH-1:0]          hm, lm, hx, lx, umin, umax, smin, smax;
   logic signed [FIELD_W-1:0] or_min_in, or_max_in, or_min_ff, or_max_ff;
   logic                      bad_ff;

   assign hm = WIDTH'(highest_one(MAX_WIDTH'(hit_a | hit_c)));
   assign hx = WIDTH'(highest_one(MAX_WIDTH'(hit_b | hit_d)));
   assign lm = hm - WIDTH'(1);
   assign lx = hx - WIDTH'(1);

   always_comb begin
      if (hm == '0) begin
         umin = lo_a | lo_c;
      end else if ((hm & hit_a) != '0) begin
         umin = ((lo_a | hm) & ~lm) | lo_c;
      end else begin
         umin = ((lo_c | hm) & ~lm) | lo_a;
      end
      if (hx == '0) begin
         umax = hi_b | hi_d;
      end else if ((hx & hit_b) != '0) begin
         umax = (hi_b & ~hx) | lx | hi_d;
      end else begin
         umax = (hi_d & ~hx) | lx | hi_b;
      end
      smin      = ctl.min_fix ? min_val : umin;
      smax      = ctl.max_fix ? '1 : umax;
      or_min_in = ctl.bad ? '0 : FIELD_W'($signed(smin));
      or_max_in = ctl.bad ? '0 : FIELD_W'($signed(smax));
   end

   always_ff @(posedge clock) begin
      if (load) begin
         or_min_ff <= or_min_in;
         or_max_ff <= or_max_in;
         bad_ff    <= ctl.bad;
      end
   end

   assign or_min    = or_min_ff;
   assign or_max    = or_max_ff;
   assign bad_range = bad_ff;

endmodule

// File: rtl/core/signed_or_range_bounds_core.sv
// Signed OR range bounds: least and greatest x | y over two signed ranges.
// Throughput 1 item per cycle while rsp_stall does not hold the pipeline.
// Three register stages (decode, per-bit scan tests, pick and output register).
// A stage fills whenever it is empty or moving on, so a stall loses nothing.
// Synchronous active-high reset empties the pipeline; no other state.
// Uses sorb_pkg, sorb_prep, sorb_scan, sorb_pick.
module signed_or_range_bounds_core #(
   parameter int WIDTH = sorb_pkg::DEF_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sorb_pkg::FIELD_W-1:0] req_a_low,
   input  logic signed [sorb_pkg::FIELD_W-1:0] req_a_high,
   input  logic signed [sorb_pkg::FIELD_W-1:0] req_b_low,
   input  logic signed [sorb_pkg::FIELD_W-1:0] req_b_high,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sorb_pkg::FIELD_W-1:0] rsp_or_min,
   output logic signed [sorb_pkg::FIELD_W-1:0] rsp_or_max,
   output logic                                rsp_bad_range
);
   import sorb_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v1_in, v2_in, v3_in;
   logic ld1, ld2, ld3;

   ctl_type          ctl1, ctl2;
   logic [WIDTH-1:0] min_a, min_b, min_c, min_d, max_a, max_b, max_c, max_d, min_val1;
   logic [WIDTH-1:0] lo_a, lo_c, hi_b, hi_d, min_val2, hit_a, hit_c, hit_b, hit_d;

   assign ld3       = !v3_ff || !rsp_stall;
   assign ld2       = !v2_ff || ld3;
   assign ld1       = !v1_ff || ld2;
   assign req_stall = !ld1;

   always_comb begin
      v1_in = ld1 ? req_valid : v1_ff;
      v2_in = ld2 ? v1_ff : v2_ff;
      v3_in = ld3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   sorb_prep #(.WIDTH(WIDTH)) u_prep (
      .clock   (clock),
      .load    (ld1),
      .a_low   (req_a_low),
      .a_high  (req_a_high),
      .b_low   (req_b_low),
      .b_high  (req_b_high),
      .ctl     (ctl1),
      .min_a   (min_a),
      .min_b   (min_b),
      .min_c   (min_c),
      .min_d   (min_d),
      .max_a   (max_a),
      .max_b   (max_b),
      .max_c   (max_c),
      .max_d   (max_d),
      .min_val (min_val1)
   );

   sorb_scan #(.WIDTH(WIDTH)) u_scan (
      .clock     (clock),
      .load      (ld2),
      .ctl_i     (ctl1),
      .min_a     (min_a),
      .min_b     (min_b),
      .min_c     (min_c),
      .min_d     (min_d),
      .max_a     (max_a),
      .max_b     (max_b),
      .max_c     (max_c),
      .max_d     (max_d),
      .min_val_i (min_val1),
      .ctl_o     (ctl2),
      .lo_a      (lo_a),
      .lo_c      (lo_c),
      .hi_b      (hi_b),
      .hi_d      (hi_d),
      .min_val_o (min_val2),
      .hit_a     (hit_a),
      .hit_c     (hit_c),
      .hit_b     (hit_b),
      .hit_d     (hit_d)
   );

   sorb_pick #(.WIDTH(WIDTH)) u_pick (
      .clock     (clock),
      .load      (ld3),
      .ctl       (ctl2),
      .lo_a      (lo_a),
      .lo_c      (lo_c),
      .hi_b      (hi_b),
      .hi_d      (hi_d),
      .min_val   (min_val2),
      .hit_a     (hit_a),
      .hit_c     (hit_c),
      .hit_b     (hit_b),
      .hit_d     (hit_d),
      .or_min    (rsp_or_min),
      .or_max    (rsp_or_max),
      .bad_range (rsp_bad_range)
   );

   assign rsp_valid = v3_ff;

   a_bad_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_range |-> rsp_or_min == '0 && rsp_or_max == '0)
      else $error("reversed range gave non-zero bounds");

   a_min_le_max : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_range |-> rsp_or_min <= rsp_or_max)
      else $error("least bound above greatest bound");

   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> v1_ff)
      else $error("accepted transfer not captured");

   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff && v2_ff && v3_ff && rsp_stall)
      else $error("input stalled with room in the pipeline");

endmodule
